@@ hw/rtl/pft_pkg.sv @@
// Package for the page frequency table: payload structs, table entry layout,
// function and register codes, sequencer states. No dependencies.
`timescale 1ns / 1ps

package pft_pkg;

  localparam int KEY_BITS  = 36;
  localparam int CNT_W     = 16;
  localparam int USED_W    = 13;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]  COUNT_MAX        = 16'hFFFF;
  localparam logic [USED_W-1:0] CAPACITY_RESET   = 13'd2500;
  localparam logic [CNT_W-1:0]  INIT_COUNT_RESET = 16'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 2'd1;

  typedef enum logic [1:0] {
    FUNC_RECORD,
    FUNC_QUERY,
    FUNC_AGE,
    FUNC_RESTART
  } pft_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } pft_state_t;

  typedef struct packed {
    pft_func_t             func;
    logic [KEY_BITS-1:0]   pfn;
  } pft_in_t;

  typedef struct packed {
    logic                  found;
    logic                  dropped;
    logic                  replaced;
    logic [USED_W-1:0]     used_entries;
  } pft_out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [CNT_W-1:0]      cnt;
  } pft_entry_t;

  // Result of the shared compare/count unit for one table entry
  typedef struct packed {
    logic                  hit;
    logic                  less;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W-1:0]      cnt_dec;
  } pft_cmp_t;

endpackage

@@ hw/rtl/pft_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pft_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/pft_unit.sv @@
// Shared compare/count unit: key match, min-count compare, saturating
// increment and floored decrement of one entry. Depends on pft_pkg.
`timescale 1ns / 1ps

module pft_unit (
  input  logic [pft_pkg::KEY_BITS-1:0] key,
  input  pft_pkg::pft_entry_t          entry,
  input  logic [pft_pkg::CNT_W-1:0]    best_cnt,
  output pft_pkg::pft_cmp_t            res
);

  always_comb begin
    res.hit     = (entry.key == key);
    res.less    = (entry.cnt < best_cnt);
    res.cnt_inc = (entry.cnt == pft_pkg::COUNT_MAX) ? entry.cnt
                                                    : entry.cnt + 1'b1;
    res.cnt_dec = (entry.cnt == '0) ? entry.cnt : entry.cnt - 1'b1;
  end

endmodule

@@ hw/rtl/page_frequency_table.sv @@
// Page frequency table top level: sequencer, table RAM, registers.
// Depends on pft_pkg, pft_ram, pft_unit.
`timescale 1ns / 1ps

// One transaction at a time. Each operation walks the occupied slots through
// the single read port of the table RAM, one slot per cycle, sharing one
// compare/count unit. From the accepting cycle until the result is loaded, a
// record passes through accept, one read per slot, pipeline drain,
// end-of-scan check, table write and result load; query, age and restart
// skip the table write, and a record dropped for budget goes from accept
// straight to result load. On an empty table the scan reads no slot. Aging
// writes each decremented count back in the cycle after its read. A new
// transaction is accepted as soon as the result is loaded into the output
// register, even while that result is still stalled. Table contents need no
// clearing pass: only slots below the fill count are read.
module page_frequency_table #(
  parameter int ENTRIES = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pft_pkg::pft_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pft_pkg::pft_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pft_pkg::CFG_W-1:0]         cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int ENT_BITS = $bits(pft_pkg::pft_entry_t);
  localparam logic [31:0] ENTRIES_U = 32'(ENTRIES);

  pft_pkg::pft_state_t state, state_next;

  logic [pft_pkg::USED_W-1:0] capacity;
  logic [pft_pkg::CNT_W-1:0]  init_count;
  logic [pft_pkg::USED_W-1:0] budget_used;
  logic [pft_pkg::USED_W-1:0] occupied;
  logic [pft_pkg::USED_W-1:0] eff_cap;

  pft_pkg::pft_func_t            op_func;
  logic [pft_pkg::KEY_BITS-1:0]  op_key;
  logic                          op_dropped;
  logic                          op_replaced;

  logic [pft_pkg::USED_W-1:0] rd_ptr;
  logic                       rd_vld;
  logic [IDX_W-1:0]           rd_idx;
  logic [pft_pkg::CNT_W-1:0]  best_cnt;
  logic [IDX_W-1:0]           best_idx;
  logic                       match_hit;
  logic [IDX_W-1:0]           match_idx;
  logic [pft_pkg::CNT_W-1:0]  match_cnt;

  logic                       ram_rd_en;
  logic [IDX_W-1:0]           ram_rd_addr;
  logic [ENT_BITS-1:0]        ram_rd_data;
  logic                       ram_wr_en;
  logic [IDX_W-1:0]           ram_wr_addr;
  pft_pkg::pft_entry_t        wr_entry;
  pft_pkg::pft_entry_t        rd_entry;
  pft_pkg::pft_cmp_t          cmp;

  logic rec_drop;
  logic table_full;
  logic scan_end;
  logic ages;
  logic out_load;

  assign eff_cap    = (32'(capacity) > ENTRIES_U) ? pft_pkg::USED_W'(ENTRIES) : capacity;
  assign rec_drop   = (in_data.func == pft_pkg::FUNC_RECORD) && (budget_used >= eff_cap);
  assign table_full = (occupied >= eff_cap);
  assign scan_end   = !rd_vld && (rd_ptr >= occupied);
  assign ages       = (op_func == pft_pkg::FUNC_AGE) || (op_func == pft_pkg::FUNC_RESTART);
  assign out_load   = (state == pft_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign rd_entry   = pft_pkg::pft_entry_t'(ram_rd_data);
  assign cfg_ready  = 1'b1;

  pft_ram #(
    .WIDTH (ENT_BITS),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ENT_BITS'(wr_entry)),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pft_unit u_unit (
    .key      (op_key),
    .entry    (rd_entry),
    .best_cnt (best_cnt),
    .res      (cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pft_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = rec_drop ? pft_pkg::ST_DONE : pft_pkg::ST_SCAN;
        end
      end
      pft_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = (op_func == pft_pkg::FUNC_RECORD) ? pft_pkg::ST_WRITE
                                                         : pft_pkg::ST_DONE;
        end
      end
      pft_pkg::ST_WRITE: begin
        state_next = pft_pkg::ST_DONE;
      end
      pft_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = pft_pkg::ST_IDLE;
        end
      end
      default: state_next = pft_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and RAM ports
  always_comb begin
    in_stall     = 1'b1;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = IDX_W'(rd_ptr);
    ram_wr_en    = 1'b0;
    ram_wr_addr  = rd_idx;
    wr_entry.key = op_key;
    wr_entry.cnt = init_count;
    case (state)
      pft_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      pft_pkg::ST_SCAN: begin
        ram_rd_en = (rd_ptr < occupied);
        // aging writes back the slot read in the previous cycle
        if (rd_vld && ages) begin
          ram_wr_en    = 1'b1;
          ram_wr_addr  = rd_idx;
          wr_entry.key = rd_entry.key;
          wr_entry.cnt = cmp.cnt_dec;
        end
      end
      pft_pkg::ST_WRITE: begin
        ram_wr_en = 1'b1;
        if (match_hit) begin
          ram_wr_addr  = match_idx;
          wr_entry.cnt = match_cnt;
        end else if (table_full) begin
          ram_wr_addr = best_idx;
        end else begin
          ram_wr_addr = IDX_W'(occupied);
        end
      end
      pft_pkg::ST_DONE: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pft_pkg::ST_IDLE;
      capacity    <= pft_pkg::CAPACITY_RESET;
      init_count  <= pft_pkg::INIT_COUNT_RESET;
      budget_used <= '0;
      occupied    <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pft_pkg::CFG_CAPACITY:   capacity   <= cfg_data[pft_pkg::USED_W-1:0];
          pft_pkg::CFG_INIT_COUNT: init_count <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        pft_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_func     <= in_data.func;
            op_key      <= in_data.pfn;
            op_dropped  <= rec_drop;
            op_replaced <= 1'b0;
            match_hit   <= 1'b0;
            rd_ptr      <= '0;
            rd_vld      <= 1'b0;
            if (in_data.func == pft_pkg::FUNC_RECORD && !rec_drop) begin
              budget_used <= budget_used + 1'b1;
            end else if (in_data.func == pft_pkg::FUNC_RESTART) begin
              budget_used <= '0;
            end
          end
        end
        pft_pkg::ST_SCAN: begin
          rd_vld <= ram_rd_en;
          rd_idx <= ram_rd_addr;
          if (ram_rd_en) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (rd_vld) begin
            if (!match_hit && cmp.hit) begin
              match_hit <= 1'b1;
              match_idx <= rd_idx;
              match_cnt <= cmp.cnt_inc;
            end
            // strict less keeps the lowest slot on ties
            if (rd_idx == '0 || cmp.less) begin
              best_cnt <= rd_entry.cnt;
              best_idx <= rd_idx;
            end
          end
        end
        pft_pkg::ST_WRITE: begin
          if (!match_hit) begin
            if (table_full) begin
              op_replaced <= 1'b1;
            end else begin
              occupied <= occupied + 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.found <= match_hit && !op_dropped &&
                        (op_func == pft_pkg::FUNC_RECORD || op_func == pft_pkg::FUNC_QUERY);
      out_data.dropped      <= op_dropped;
      out_data.replaced     <= op_replaced;
      out_data.used_entries <= occupied;
    end
  end

`ifndef SYNTHESIS
  a_scan_write_only_aging: assert property (@(posedge clk) disable iff (rst)
    (state == pft_pkg::ST_SCAN && ram_wr_en) |->
      (op_func == pft_pkg::FUNC_AGE || op_func == pft_pkg::FUNC_RESTART))
    else $error("table write during scan outside aging");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && occupied != $past(occupied)) |->
      ($past(state) == pft_pkg::ST_WRITE &&
       occupied == pft_pkg::USED_W'($past(occupied) + 1'b1)))
    else $error("fill count moved outside an insert");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> ($past(state) == pft_pkg::ST_DONE))
    else $error("result raised outside the done state");
`endif

endmodule

@@ verif/pft_table_checker.sv @@
// Checker for the page frequency table: watches the input, output and register
// channels, predicts each result and compares it field by field.
// Depends on pft_pkg.
`timescale 1ns / 1ps

module pft_table_checker #(
  parameter int ENTRIES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  pft_pkg::pft_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  pft_pkg::pft_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pft_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            outstanding
);

  logic [pft_pkg::KEY_BITS-1:0] tbl_keys   [ENTRIES];
  logic [pft_pkg::CNT_W-1:0]    tbl_counts [ENTRIES];
  int unsigned                  tbl_fill;
  int unsigned                  budget_spent;
  logic [pft_pkg::USED_W-1:0]   cap_reg;
  logic [pft_pkg::CNT_W-1:0]    init_cnt_reg;
  pft_pkg::pft_out_t            expected_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic age_counts();
    int unsigned i;
    for (i = 0; i < tbl_fill; i++) begin
      if (tbl_counts[i] != '0) tbl_counts[i] = tbl_counts[i] - 1'b1;
    end
  endtask

  // Applies one operation to the table copy and returns the result it gives.
  task automatic apply_op(input pft_pkg::pft_in_t op, output pft_pkg::pft_out_t res);
    int unsigned cap;
    int unsigned i;
    int          hit;
    int unsigned best;
    res = '0;
    cap = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    hit = -1;
    for (i = 0; i < tbl_fill; i++) begin
      if (hit < 0 && tbl_keys[i] == op.pfn) hit = i;
    end
    case (op.func)
      pft_pkg::FUNC_RECORD: begin
        if (budget_spent >= cap) begin
          res.dropped = 1'b1;
        end else begin
          budget_spent++;
          if (hit >= 0) begin
            res.found = 1'b1;
            if (tbl_counts[hit] != pft_pkg::COUNT_MAX)
              tbl_counts[hit] = tbl_counts[hit] + 1'b1;
          end else if (tbl_fill >= cap) begin
            // evict the lowest count, first slot wins a tie
            best = 0;
            for (i = 1; i < tbl_fill; i++) begin
              if (tbl_counts[i] < tbl_counts[best]) best = i;
            end
            tbl_keys[best]   = op.pfn;
            tbl_counts[best] = init_cnt_reg;
            res.replaced     = 1'b1;
          end else begin
            tbl_keys[tbl_fill]   = op.pfn;
            tbl_counts[tbl_fill] = init_cnt_reg;
            tbl_fill++;
          end
        end
      end
      pft_pkg::FUNC_QUERY: res.found = (hit >= 0);
      pft_pkg::FUNC_AGE: age_counts();
      default: begin
        age_counts();
        budget_spent = 0;
      end
    endcase
    res.used_entries = tbl_fill[pft_pkg::USED_W-1:0];
  endtask

  always @(posedge clk) begin
    pft_pkg::pft_out_t want;
    pft_pkg::pft_out_t got;
    if (rst) begin
      tbl_fill     = 0;
      budget_spent = 0;
      cap_reg      = pft_pkg::CAPACITY_RESET;
      init_cnt_reg = pft_pkg::INIT_COUNT_RESET;
      expected_results.delete();
      outstanding  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: %h", got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped: expected %0d, got %0d", want.dropped, got.dropped);
            fail_count++;
          end
          if (got.replaced !== want.replaced) begin
            $error("replaced: expected %0d, got %0d", want.replaced, got.replaced);
            fail_count++;
          end
          if (got.used_entries !== want.used_entries) begin
            $error("used_entries: expected %0d, got %0d", want.used_entries,
                   got.used_entries);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_op(in_data, want);
        expected_results.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pft_pkg::CFG_CAPACITY:   cap_reg = cfg_data[pft_pkg::USED_W-1:0];
          pft_pkg::CFG_INIT_COUNT: init_cnt_reg = cfg_data[pft_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      outstanding = expected_results.size();
    end
  end

endmodule

@@ verif/tb_page_frequency_table.sv @@
// Testbench top for the page frequency table: clock, reset, register writes,
// operation stimulus with idle and stall patterns, final verdict.
// Depends on pft_pkg, page_frequency_table and pft_table_checker.
`timescale 1ns / 1ps

module tb_page_frequency_table;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int POOL_SIZE    = 10;

  localparam logic [pft_pkg::KEY_BITS-1:0] KEY_ZERO = '0;
  localparam logic [pft_pkg::KEY_BITS-1:0] KEY_ONES = '1;
  localparam logic [pft_pkg::KEY_BITS-1:0] KEY_ALT  = 36'hA_5A5A_5A5A;
  localparam logic [pft_pkg::KEY_BITS-1:0] KEY_INV  = 36'h5_A5A5_A5A5;

  typedef enum int {
    MODE_NONE,
    MODE_TX,
    MODE_RX,
    MODE_BOTH
  } idle_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  pft_pkg::pft_in_t              in_data;
  logic                          out_valid;
  logic                          out_stall;
  pft_pkg::pft_out_t             out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pft_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pft_pkg::CFG_W-1:0]     cfg_data;

  int                            fail_count;
  int                            outstanding;
  int                            cycle_count;
  int                            tx_pct;
  int                            rx_pct;
  int                            hold_req;
  int                            hold_seen;
  int                            hold_left;
  logic [pft_pkg::KEY_BITS-1:0]  key_pool [POOL_SIZE];

  page_frequency_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pft_table_checker mon (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    cycle_count = 0;
    tx_pct      = 0;
    rx_pct      = 0;
    hold_req    = 0;
    hold_seen   = 0;
    hold_left   = 0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < rx_pct);
    end
  end

  task automatic set_mode(input idle_mode_t mode);
    case (mode)
      MODE_TX:   begin tx_pct = 66; rx_pct = 0;  end
      MODE_RX:   begin tx_pct = 0;  rx_pct = 66; end
      MODE_BOTH: begin tx_pct = 15; rx_pct = 15; end
      default:   begin tx_pct = 0;  rx_pct = 0;  end
    endcase
  endtask

  task automatic write_reg(input logic [pft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pft_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Valid stays high between back-to-back transactions unless a random idle gap is drawn
  task automatic send_op(input pft_pkg::pft_func_t f,
                         input logic [pft_pkg::KEY_BITS-1:0] k);
    pft_pkg::pft_in_t op;
    op.func = f;
    op.pfn  = k;
    @(negedge clk);
    while ($urandom_range(99, 0) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random_op();
    logic [63:0]                  r;
    logic [pft_pkg::KEY_BITS-1:0] k;
    int                           roll;
    pft_pkg::pft_func_t           f;
    r    = {$urandom(), $urandom()};
    k    = ($urandom_range(99, 0) < 25) ? r[pft_pkg::KEY_BITS-1:0]
                                        : key_pool[$urandom_range(POOL_SIZE-1, 0)];
    roll = $urandom_range(99, 0);
    if (roll < 60)      f = pft_pkg::FUNC_RECORD;
    else if (roll < 75) f = pft_pkg::FUNC_QUERY;
    else if (roll < 85) f = pft_pkg::FUNC_AGE;
    else                f = pft_pkg::FUNC_RESTART;
    send_op(f, k);
  endtask

  task automatic run_phase(input logic [pft_pkg::CFG_W-1:0] cap,
                           input logic [pft_pkg::CFG_W-1:0] init,
                           input idle_mode_t mode, input int n, input bit hold_off);
    drain();
    write_reg(pft_pkg::CFG_CAPACITY, cap);
    write_reg(pft_pkg::CFG_INIT_COUNT, init);
    set_mode(mode);
    send_op(pft_pkg::FUNC_RESTART, KEY_ZERO);
    if (hold_off) hold_req++;
    repeat (n) send_random_op();
  endtask

  initial begin
    logic [63:0] r;
    for (int i = 0; i < POOL_SIZE; i++) begin
      r = {$urandom(), $urandom()};
      key_pool[i] = r[pft_pkg::KEY_BITS-1:0];
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings
    set_mode(MODE_NONE);
    send_op(pft_pkg::FUNC_QUERY,   KEY_ZERO);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ZERO);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ZERO);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ONES);
    send_op(pft_pkg::FUNC_QUERY,   KEY_ONES);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ALT);
    send_op(pft_pkg::FUNC_AGE,     KEY_ZERO);
    send_op(pft_pkg::FUNC_QUERY,   KEY_INV);
    send_op(pft_pkg::FUNC_RESTART, KEY_ONES);

    // Capacity below fill: table counts as full, count saturates, budget runs out
    drain();
    write_reg(pft_pkg::CFG_CAPACITY, 16'd2);
    write_reg(pft_pkg::CFG_INIT_COUNT, 16'hFFFF);
    send_op(pft_pkg::FUNC_RECORD, KEY_INV);
    send_op(pft_pkg::FUNC_RECORD, KEY_INV);
    send_op(pft_pkg::FUNC_RECORD, KEY_ALT);
    send_op(pft_pkg::FUNC_QUERY,  KEY_INV);

    // Zero capacity drops every record
    drain();
    write_reg(pft_pkg::CFG_CAPACITY, 16'd0);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ALT);
    send_op(pft_pkg::FUNC_RESTART, KEY_ZERO);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ALT);

    // Capacity one, zero initial count: aging holds at zero, the zero count is evicted
    drain();
    write_reg(pft_pkg::CFG_CAPACITY, 16'd1);
    write_reg(pft_pkg::CFG_INIT_COUNT, 16'd0);
    send_op(pft_pkg::FUNC_RESTART, KEY_ZERO);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ONES);
    send_op(pft_pkg::FUNC_AGE,     KEY_ZERO);
    send_op(pft_pkg::FUNC_RESTART, KEY_ZERO);
    send_op(pft_pkg::FUNC_RECORD,  KEY_ALT);
    send_op(pft_pkg::FUNC_QUERY,   KEY_ONES);

    run_phase(16'd8,    16'($urandom_range(65535, 0)), MODE_NONE, 25, 1'b0);
    run_phase(16'd4,    16'd0,                         MODE_TX,   25, 1'b0);
    // capacity field all ones, limited to the table size
    run_phase(16'hFFFF, 16'hFFFF,                      MODE_RX,   20, 1'b0);
    run_phase(16'd6,    16'd3,                         MODE_BOTH, 25, 1'b0);
    run_phase(16'd5,    16'($urandom_range(65535, 0)), MODE_NONE, 20, 1'b1);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
